[rtl/core/kmcq_pkg.sv]
// kmcq_pkg: shared types, codes and helpers of the k-means color quantizer
// no dependencies; compiled before every other file of the block
`default_nettype none

package kmcq_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned DIST_W      = 18;
  localparam int unsigned MAX_RESULTS = 12;
  localparam int unsigned QUO_STEPS   = 8;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ACCUM  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_MAP    = 2'd3
  } cmd_e;

  // channel 0 is red in bits 7..0, channel 2 is blue
  typedef struct packed {
    logic                         alpha;
    logic [NUM_CH-1:0][CH_W-1:0]  col;
  } mean_t;

  function automatic logic [2*CH_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

`default_nettype wire

[rtl/core/kmcq_in_if.sv]
// kmcq_in_if: command channel of the k-means color quantizer
// depends on kmcq_pkg for field widths
`default_nettype none

interface kmcq_in_if;
  import kmcq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] mean_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  modport source (output valid, command, mean_index, red, green, blue, input ready);
  modport sink   (input valid, command, mean_index, red, green, blue, output ready);
endinterface

`default_nettype wire

[rtl/core/kmcq_out_if.sv]
// kmcq_out_if: result channel of the k-means color quantizer
// depends on kmcq_pkg for field widths
`default_nettype none

interface kmcq_out_if;
  import kmcq_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cluster_index;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [CH_W-1:0]  out_alpha;
  logic             last;

  modport source (output valid, cluster_index, out_red, out_green, out_blue, out_alpha,
                  last, input ready);
  modport sink   (input valid, cluster_index, out_red, out_green, out_blue, out_alpha,
                  last, output ready);
endinterface

`default_nettype wire

[rtl/core/kmeans_color_quantizer.sv]
// kmeans_color_quantizer: one k-means pass engine for rgb color quantization
// depends on kmcq_pkg, kmcq_in_if and kmcq_out_if
//
// One command is taken at a time. A load writes the mean memory from the idle
// state. Accumulate and map scan the mean memory one entry per cycle through
// a three-stage read, distance and compare pipeline; accumulate then reads
// and writes back the accumulator of the nearest mean, and both emit one
// result before the next command can enter. Finish walks the accumulator
// memory one cluster at a time: read, load, the bit-serial divider that forms
// all three channel averages together (skipped for an empty cluster), write.
// Results sit in an output register, so a stalled result channel delays the
// block only when a second result is due. Means and accumulators reset to zero
// through per-entry valid bits, with no clearing pass.
`default_nettype none

module kmeans_color_quantizer #(
  parameter int unsigned NUM_MEANS  = 12,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kmcq_in_if.sink           in_i,
  kmcq_out_if.source        out_o
);
  import kmcq_pkg::*;

  localparam int unsigned ADDR_W = $clog2(NUM_MEANS);
  localparam int unsigned CNT_W  = $clog2(NUM_MEANS + 1);
  localparam int unsigned SUM_W  = COUNT_BITS + CH_W;
  localparam int unsigned SHOWN  = (NUM_MEANS < MAX_RESULTS) ? NUM_MEANS : MAX_RESULTS;
  localparam logic [ADDR_W-1:0]     LAST_IDX  = ADDR_W'(NUM_MEANS - 1);
  localparam logic [ADDR_W-1:0]     SHOWN_END = ADDR_W'(SHOWN - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0]          count;
    logic [NUM_CH-1:0][SUM_W-1:0]   sum;
  } acc_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SRCH    = 9'b000000010,
    S_ACC_RD  = 9'b000000100,
    S_ACC_WR  = 9'b000001000,
    S_EMIT    = 9'b000010000,
    S_FIN_RD  = 9'b000100000,
    S_FIN_LD  = 9'b001000000,
    S_FIN_DIV = 9'b010000000,
    S_FIN_WR  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic                        in_fire;
  logic                        out_free;
  cmd_e                        cmd_q;
  logic [NUM_CH-1:0][CH_W-1:0] pix_q;

  // mean memory
  mean_t                 mean_mem [NUM_MEANS];
  logic [NUM_MEANS-1:0]  mean_vld_q;
  mean_t                 mean_rdata_q;
  logic                  mean_rvld_q;
  logic [ADDR_W-1:0]     mean_raddr;
  logic                  mean_we;
  logic [ADDR_W-1:0]     mean_waddr;
  mean_t                 mean_wdata;

  // accumulator memory
  acc_t                  acc_mem [NUM_MEANS];
  logic [NUM_MEANS-1:0]  acc_vld_q;
  acc_t                  acc_rdata_q;
  logic                  acc_rvld_q;
  logic [ADDR_W-1:0]     acc_raddr;
  acc_t                  acc_cur;
  acc_t                  acc_nxt;
  logic                  acc_we;
  logic                  acc_clr;

  // search pipeline
  logic [CNT_W-1:0]      issue_cnt_q, issue_cnt_d;
  logic                  issue_act;
  logic                  p1_vld_q;
  logic [ADDR_W-1:0]     p1_idx_q;
  logic                  p2_vld_q;
  logic [ADDR_W-1:0]     p2_idx_q;
  logic [DIST_W-1:0]     p2_dist_q;
  mean_t                 p2_mean_q;
  mean_t                 p1_mean;
  logic [DIST_W-1:0]     p1_dist;
  logic [ADDR_W-1:0]     best_idx_q;
  logic [DIST_W-1:0]     best_dist_q;
  mean_t                 best_mean_q;
  logic                  srch_done;

  // finish sweep and divider
  logic [ADDR_W-1:0]           fin_idx_q, fin_idx_d;
  logic                        fin_show;
  logic                        fin_nz_q;
  logic [SUM_W-1:0]            dsr_q;
  logic [NUM_CH-1:0][SUM_W-1:0] rem_q;
  logic [NUM_CH-1:0][CH_W-1:0] quo_q;
  logic [2:0]                  step_q;

  // output register
  logic                  out_vld_q, out_vld_d;
  logic                  out_load;
  logic [ADDR_W-1:0]     out_src_idx;
  mean_t                 out_src_mean;
  logic                  out_src_last;
  logic [IDX_W-1:0]      out_idx_q;
  mean_t                 out_mean_q;
  logic                  out_last_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  assign issue_act  = (state_q == S_SRCH) && (issue_cnt_q < CNT_W'(NUM_MEANS));
  assign mean_raddr = issue_cnt_q[ADDR_W-1:0];
  assign srch_done  = p2_vld_q && (p2_idx_q == LAST_IDX);

  assign acc_raddr  = (state_q == S_ACC_RD) ? best_idx_q : fin_idx_q;
  assign acc_cur    = acc_rvld_q ? acc_rdata_q : '0;
  assign fin_show   = (fin_idx_q <= SHOWN_END);

  always_comb begin
    acc_nxt.count = acc_cur.count + COUNT_BITS'(1);
    for (int c = 0; c < NUM_CH; c++) begin
      acc_nxt.sum[c] = acc_cur.sum[c] + SUM_W'(pix_q[c]);
    end
  end

  always_comb begin
    p1_mean = mean_rvld_q ? mean_rdata_q : '0;
    p1_dist = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      p1_dist = p1_dist + DIST_W'(sq_diff(pix_q[c], p1_mean.col[c]));
    end
  end

  always_comb begin
    state_d      = state_q;
    issue_cnt_d  = issue_act ? issue_cnt_q + CNT_W'(1) : issue_cnt_q;
    fin_idx_d    = fin_idx_q;
    mean_we      = 1'b0;
    mean_waddr   = fin_idx_q;
    mean_wdata   = '0;
    mean_wdata.alpha = fin_nz_q;
    mean_wdata.col   = quo_q;
    acc_we       = 1'b0;
    acc_clr      = 1'b0;
    out_load     = 1'b0;
    out_src_idx  = best_idx_q;
    out_src_mean = best_mean_q;
    out_src_last = 1'b1;
    case (state_q)
      S_IDLE: begin
        issue_cnt_d = '0;
        fin_idx_d   = '0;
        if (in_fire) begin
          case (cmd_e'(in_i.command))
            CMD_LOAD: begin
              if (32'(in_i.mean_index) < NUM_MEANS) begin
                mean_we          = 1'b1;
                mean_waddr       = ADDR_W'(in_i.mean_index);
                mean_wdata.alpha = 1'b1;
                mean_wdata.col   = {in_i.blue, in_i.green, in_i.red};
              end
            end
            CMD_FINISH: state_d = S_FIN_RD;
            default:    state_d = S_SRCH;
          endcase
        end
      end
      S_SRCH: begin
        if (srch_done) begin
          state_d = (cmd_q == CMD_ACCUM) ? S_ACC_RD : S_EMIT;
        end
      end
      S_ACC_RD: state_d = S_ACC_WR;
      S_ACC_WR: begin
        acc_we  = (acc_cur.count != COUNT_MAX);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_FIN_RD: state_d = S_FIN_LD;
      S_FIN_LD: state_d = (acc_cur.count == '0) ? S_FIN_WR : S_FIN_DIV;
      S_FIN_DIV: begin
        if (step_q == 3'(QUO_STEPS - 1)) begin
          state_d = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        out_src_idx  = fin_idx_q;
        out_src_mean = mean_wdata;
        out_src_last = (fin_idx_q == SHOWN_END);
        if (!fin_show || out_free) begin
          mean_we  = 1'b1;
          acc_clr  = 1'b1;
          out_load = fin_show;
          if (fin_idx_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            fin_idx_d = fin_idx_q + ADDR_W'(1);
            state_d   = S_FIN_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !out_o.ready);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_cnt_q <= '0;
      fin_idx_q   <= '0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      mean_vld_q  <= '0;
      mean_rvld_q <= 1'b0;
      acc_vld_q   <= '0;
      acc_rvld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      fin_idx_q   <= fin_idx_d;
      p1_vld_q    <= issue_act;
      p2_vld_q    <= p1_vld_q;
      mean_rvld_q <= mean_vld_q[mean_raddr];
      acc_rvld_q  <= acc_vld_q[acc_raddr];
      out_vld_q   <= out_vld_d;
      if (mean_we) begin
        mean_vld_q[mean_waddr] <= 1'b1;
      end
      if (acc_we) begin
        acc_vld_q[best_idx_q] <= 1'b1;
      end
      if (acc_clr) begin
        acc_vld_q[fin_idx_q] <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[mean_waddr] <= mean_wdata;
    end
    mean_rdata_q <= mean_mem[mean_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[best_idx_q] <= acc_nxt;
    end
    acc_rdata_q <= acc_mem[acc_raddr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= cmd_e'(in_i.command);
      pix_q       <= {in_i.blue, in_i.green, in_i.red};
      best_dist_q <= '1;
    end else if (p2_vld_q && (p2_dist_q < best_dist_q)) begin
      best_dist_q <= p2_dist_q;
      best_idx_q  <= p2_idx_q;
      best_mean_q <= p2_mean_q;
    end
    p1_idx_q  <= mean_raddr;
    p2_idx_q  <= p1_idx_q;
    p2_dist_q <= p1_dist;
    p2_mean_q <= p1_mean;

    case (state_q)
      S_FIN_LD: begin
        dsr_q    <= {1'b0, acc_cur.count, 7'b0};
        rem_q    <= acc_cur.sum;
        quo_q    <= '0;
        step_q   <= '0;
        fin_nz_q <= (acc_cur.count != '0);
      end
      S_FIN_DIV: begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (rem_q[c] >= dsr_q) begin
            rem_q[c] <= rem_q[c] - dsr_q;
            quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b1};
          end else begin
            quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b0};
          end
        end
        dsr_q  <= dsr_q >> 1;
        step_q <= step_q + 3'd1;
      end
      default: ;
    endcase

    if (out_load) begin
      out_idx_q  <= IDX_W'(out_src_idx);
      out_mean_q <= out_src_mean;
      out_last_q <= out_src_last;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.cluster_index = out_idx_q;
  assign out_o.out_red       = out_mean_q.col[0];
  assign out_o.out_green     = out_mean_q.col[1];
  assign out_o.out_blue      = out_mean_q.col[2];
  assign out_o.out_alpha     = out_mean_q.alpha ? ALPHA_OPAQUE : ALPHA_CLEAR;
  assign out_o.last          = out_last_q;

endmodule

`default_nettype wire

[rtl/core/kmcq_checker.sv]
// kmcq_checker: port-level assertions for kmeans_color_quantizer
// depends on kmcq_pkg; bound to the top level at the end of this file
`default_nettype none

module kmcq_checker #(
  parameter int unsigned NUM_MEANS = 12
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [kmcq_pkg::CMD_W-1:0] in_command_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [kmcq_pkg::IDX_W-1:0] out_index_i,
  input logic [kmcq_pkg::CH_W-1:0]  out_red_i,
  input logic [kmcq_pkg::CH_W-1:0]  out_green_i,
  input logic [kmcq_pkg::CH_W-1:0]  out_blue_i,
  input logic [kmcq_pkg::CH_W-1:0]  out_alpha_i,
  input logic                       out_last_i
);
  import kmcq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_index_i, out_red_i, out_green_i, out_blue_i, out_alpha_i, out_last_i}))
    else $error("stalled result changed");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_alpha_i == ALPHA_OPAQUE) ||
      (out_alpha_i == ALPHA_CLEAR && out_red_i == '0 && out_green_i == '0 && out_blue_i == '0))
    else $error("empty-cluster mean is not black or alpha is neither 0 nor 255");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && NUM_MEANS <= 16 |-> 32'(out_index_i) < NUM_MEANS)
    else $error("cluster index beyond the mean table");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i != CMD_LOAD |=> !in_ready_i)
    else $error("new command taken while a scan or finish is running");

endmodule

bind kmeans_color_quantizer kmcq_checker #(.NUM_MEANS(NUM_MEANS)) u_kmcq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_index_i  (out_o.cluster_index),
  .out_red_i    (out_o.out_red),
  .out_green_i  (out_o.out_green),
  .out_blue_i   (out_o.out_blue),
  .out_alpha_i  (out_o.out_alpha),
  .out_last_i   (out_o.last)
);

`default_nettype wire
